>>> hw/rtl/fca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// Operation and status codes, sequencer state codes for the allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam logic [2:0] OP_FORMAT = 3'd0;
    localparam logic [2:0] OP_CREATE = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_APPEND = 3'd3;
    localparam logic [2:0] OP_CHECK  = 3'd4;
    localparam logic [2:0] OP_DELETE = 3'd5;
    localparam logic [2:0] OP_FIRST  = 3'd6;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EXISTS      = 3'd1;
    localparam logic [2:0] ST_DIR_FULL    = 3'd2;
    localparam logic [2:0] ST_NO_FREE     = 3'd3;
    localparam logic [2:0] ST_NO_FILE     = 3'd4;
    localparam logic [2:0] ST_NOT_IN_FILE = 3'd5;

    typedef logic [3:0] t_state;

    localparam t_state S_IDLE   = 4'd0;
    localparam t_state S_FMT    = 4'd1;
    localparam t_state S_SRCH   = 4'd2;
    localparam t_state S_DISP   = 4'd3;
    localparam t_state S_HEAD   = 4'd4;
    localparam t_state S_POP    = 4'd5;
    localparam t_state S_TAIL   = 4'd6;
    localparam t_state S_TAILW  = 4'd7;
    localparam t_state S_WALK   = 4'd8;
    localparam t_state S_WALKW  = 4'd9;
    localparam t_state S_DEL0   = 4'd10;
    localparam t_state S_DEL1   = 4'd11;
    localparam t_state S_DEL2   = 4'd12;
    localparam t_state S_OUT    = 4'd13;
    localparam t_state S_POPW   = 4'd14;
    localparam t_state S_DELW   = 4'd15;

endpackage

>>> hw/rtl/fat_chain_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Allocation table of chained block links with a flat file directory.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata = operation[2:0], file_key[18:3], block_number[26:19]
//  m_axis    out  tdata = status[2:0], block_value[10:3]
//
//  A directory operation searches all DIR_ENTRIES slots, then dispatches
//  and presents the result; each chain step is an address, then the read
//  data of the one-port table memory. Append pops the free list, delete
//  returns the block to it; a format sweeps NUM_BLOCKS entries. Reset clears
//  the state, result valid, directory used bits and table-written flag only.
//  s_axis_tready is low from acceptance until the result is taken.
module fat_chain_allocator
    import fca_pkg::*;
#(
    parameter int NUM_BLOCKS   = 256,
    parameter int DIR_ENTRIES  = 16,
    parameter int TABLE_BLOCKS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // operation, file_key, block_number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // status, block_value
);

    localparam int BW  = $clog2(NUM_BLOCKS);
    localparam int DW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int LW  = BW + 1;
    localparam int FB  = 2 + TABLE_BLOCKS;
    localparam logic [LW-1:0] RSV = '1;

    // table memory, one port
    logic [LW-1:0] r_mem [NUM_BLOCKS];
    logic [LW-1:0] r_rd;
    logic          mem_we;
    logic [BW-1:0] mem_addr;
    logic [LW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr];
    end

    // directory
    logic [15:0]   r_dkey   [DIR_ENTRIES];
    logic [BW-1:0] r_dfirst [DIR_ENTRIES];
    logic [DIR_ENTRIES-1:0] r_dused;

    logic          r_fmt_done;
    t_state        r_st, n_st;
    logic [2:0]    r_op;
    logic [15:0]   r_key;
    logic [BW-1:0] r_blk;
    logic [BW:0]   r_cnt;
    logic          r_hit, r_free_ok;
    logic [DW-1:0] r_hslot, r_fslot;
    logic [BW-1:0] r_head, r_cur, r_prev;
    logic [2:0]    r_status;
    logic [BW-1:0] r_value;
    logic          r_ovalid;

    logic [DW-1:0] slot;
    logic [LW-1:0] rd;
    logic          link_end;
    logic [BW-1:0] link_b;
    logic          tail_end;

    assign slot     = r_cnt[DW-1:0];
    assign rd       = r_fmt_done ? r_rd : '0;
    assign link_end = (rd == '0) || (rd >= LW'(NUM_BLOCKS));
    assign link_b   = link_end ? '0 : rd[BW-1:0];
    assign tail_end = link_end || (r_cnt == (BW+1)'(NUM_BLOCKS));
    assign n_st     = r_st;

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = 16'({r_value, r_status});

    // memory port steering
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = '0;
        mem_wd   = '0;
        case (r_st)
            S_FMT: begin
                mem_we   = 1'b1;
                mem_addr = r_cnt[BW-1:0];
                if (r_cnt == '0) begin
                    mem_wd = (FB < NUM_BLOCKS) ? LW'(FB) : '0;
                end else if (r_cnt < (BW+1)'(FB)) begin
                    mem_wd = RSV;
                end else if (r_cnt + 1'b1 < (BW+1)'(NUM_BLOCKS)) begin
                    mem_wd = LW'(r_cnt + 1'b1);
                end else begin
                    mem_wd = '0;
                end
            end
            S_HEAD:  mem_addr = '0;
            S_POP:   mem_addr = rd[BW-1:0];
            S_POPW: begin
                mem_we = 1'b1; mem_addr = '0; mem_wd = rd;
            end
            S_TAIL:  mem_addr = r_cur;
            // link the new block behind the last one
            S_TAILW: begin
                mem_addr = r_cur;
                if (tail_end) begin
                    mem_we = 1'b1; mem_wd = LW'(r_value);
                end
            end
            S_WALK:  mem_addr = r_cur;
            S_DEL0:  mem_addr = '0;
            S_DEL1: begin
                mem_we = 1'b1; mem_addr = r_blk; mem_wd = rd;
            end
            S_DEL2: begin
                mem_we = 1'b1; mem_addr = '0; mem_wd = LW'(r_blk);
            end
            S_DELW: begin
                mem_we = 1'b1; mem_addr = r_prev; mem_wd = LW'(r_head);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_dused    <= '0;
            r_fmt_done <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (r_ovalid && m_axis_tready) begin
                        r_ovalid <= 1'b0;
                    end
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op      <= s_axis_tdata[2:0];
                        r_key     <= s_axis_tdata[18:3];
                        r_blk     <= BW'(s_axis_tdata[26:19]);
                        r_cnt     <= '0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_status  <= ST_OK;
                        r_value   <= '0;
                        r_st      <= (s_axis_tdata[2:0] == OP_FORMAT) ? S_FMT : S_SRCH;
                    end
                end
                S_FMT: begin
                    if (r_cnt == (BW+1)'(NUM_BLOCKS - 1)) begin
                        r_dused    <= '0;
                        for (int i = 0; i < DIR_ENTRIES; i++) r_dfirst[i] <= '0;
                        r_fmt_done <= 1'b1;
                        r_st       <= S_OUT;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                // scan slots: first hit on key, first free slot
                S_SRCH: begin
                    if (r_dused[slot] && r_dkey[slot] == r_key && !r_hit) begin
                        r_hit   <= 1'b1;
                        r_hslot <= slot;
                    end
                    if (!r_dused[slot] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_fslot   <= slot;
                    end
                    if (r_cnt == (BW+1)'(DIR_ENTRIES - 1)) begin
                        r_st <= S_DISP;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_DISP: begin
                    r_cnt <= '0;
                    r_st  <= S_OUT;
                    case (r_op)
                        OP_CREATE: begin
                            if (r_hit) r_status <= ST_EXISTS;
                            else if (!r_free_ok) r_status <= ST_DIR_FULL;
                            else begin
                                r_dused[r_fslot]  <= 1'b1;
                                r_dkey[r_fslot]   <= r_key;
                                r_dfirst[r_fslot] <= '0;
                            end
                        end
                        OP_REMOVE: begin
                            if (!r_hit) r_status <= ST_NO_FILE;
                            else r_dused[r_hslot] <= 1'b0;
                        end
                        OP_APPEND: r_st <= S_HEAD;
                        OP_CHECK, OP_DELETE: begin
                            if (!r_hit) r_status <= ST_NO_FILE;
                            else begin
                                r_cur  <= r_dfirst[r_hslot];
                                r_prev <= '0;
                                r_st   <= S_WALK;
                            end
                        end
                        OP_FIRST: begin
                            if (!r_hit) r_status <= ST_NO_FILE;
                            else r_value <= r_dfirst[r_hslot];
                        end
                        default: ;
                    endcase
                end
                S_HEAD: r_st <= S_POP;
                S_POP: begin
                    if (link_end) begin
                        r_status <= ST_NO_FREE;
                        r_st     <= S_OUT;
                    end else if (!r_hit) begin
                        r_status <= ST_NO_FILE;
                        r_st     <= S_OUT;
                    end else begin
                        r_head  <= rd[BW-1:0];
                        r_value <= rd[BW-1:0];
                        r_st    <= S_POPW;
                    end
                end
                // advance the free head; clear the popped link next
                S_POPW: begin
                    r_cur  <= r_dfirst[r_hslot];
                    r_prev <= r_head;
                    r_head <= '0;
                    r_st   <= S_DELW;
                end
                S_TAIL: r_st <= S_TAILW;
                S_TAILW: begin
                    if (tail_end) begin
                        r_st <= S_OUT;
                    end else begin
                        r_cur <= rd[BW-1:0];
                        r_cnt <= r_cnt + 1'b1;
                        r_st  <= S_TAIL;
                    end
                end
                S_WALK: r_st <= S_WALKW;
                S_WALKW: begin
                    if (r_cur == '0 || r_cnt == (BW+1)'(NUM_BLOCKS)) begin
                        r_status <= ST_NOT_IN_FILE;
                        r_st     <= S_OUT;
                    end else if (r_cur == r_blk) begin
                        if (r_op == OP_CHECK) begin
                            r_value <= link_b;
                            r_st    <= S_OUT;
                        end else begin
                            r_head <= link_b;
                            if (r_prev == '0) r_dfirst[r_hslot] <= link_b;
                            r_st <= (r_prev == '0) ? S_DEL0 : S_DELW;
                        end
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= link_b;
                        r_cnt  <= r_cnt + 1'b1;
                        r_st   <= S_WALK;
                    end
                end
                // delete goes on to free the block; append: empty file takes the block as first, else walk to the tail
                S_DELW: begin
                    if (r_op == OP_DELETE) begin
                        r_st <= S_DEL0;
                    end else if (r_cur == '0) begin
                        r_dfirst[r_hslot] <= r_value;
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_TAIL;
                    end
                end
                S_DEL0: r_st <= S_DEL1;
                S_DEL1: r_st <= S_DEL2;
                S_DEL2: r_st <= S_OUT;
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/fca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fca_checker
    import fca_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // no new transfer while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready with result pending");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");

    // status code is in range
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_NOT_IN_FILE) else $error("bad status");

    // errors carry a zero value
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[10:3] == 8'd0)
        else $error("value on error");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (.*);
